// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rstn, prop, msg)

`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/cdgm_pkg.sv
package cdgm_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ADDR_W       = COL_W + 1;
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = 12;
    localparam int IN_ROW_W     = HEIGHT_W;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam int SAMPLE_W     = 16;
    localparam int GRAD_W       = SAMPLE_W + 1;
    localparam int ABS_W        = SAMPLE_W;
    localparam int SQ_W         = 2 * ABS_W;
    localparam int MAG_W        = 17;
    localparam int RAD_W        = 2 * MAG_W;
    localparam int REM_W        = MAG_W + 3;
    localparam int ITER_CNT_W   = $clog2(MAG_W + 1);

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_L,
        ST_RD_R,
        ST_RD_C,
        ST_RD_A,
        ST_DIFF,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic             busy;
        logic [MAG_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// File: rtl/cdgm_if.sv
interface cdgm_pix_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic signed [cdgm_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface cdgm_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cdgm_pkg::GRAD_W-1:0]    grad_x;
    logic signed [cdgm_pkg::GRAD_W-1:0]    grad_y;
    logic        [cdgm_pkg::MAG_W-1:0]     magnitude;
    logic                                  frame_end;

    modport source (output valid, output grad_x, output grad_y, output magnitude,
                    output frame_end, input ready);
    modport sink   (input valid, input grad_x, input grad_y, input magnitude,
                    input frame_end, output ready);
endinterface

interface cdgm_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [cdgm_pkg::CFG_IDX_W-1:0]        index;
    logic [cdgm_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/cdgm_ram.sv
module cdgm_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/cdgm_isqrt.sv
module cdgm_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  cdgm_pkg::sqrt_req_t req,
    output cdgm_pkg::sqrt_rsp_t rsp
);

    logic                                busy_reg;
    logic [cdgm_pkg::ITER_CNT_W-1:0]     cnt_reg;
    logic [cdgm_pkg::RAD_W-1:0]          rad_reg;
    logic [cdgm_pkg::REM_W-1:0]          rem_reg;
    logic [cdgm_pkg::MAG_W-1:0]          root_reg;

    logic [cdgm_pkg::REM_W-1:0]          rem_shift;
    logic [cdgm_pkg::REM_W-1:0]          trial;
    logic                                fits;
    logic [cdgm_pkg::REM_W-1:0]          rem_next;
    logic [cdgm_pkg::MAG_W-1:0]          root_next;
    logic [cdgm_pkg::RAD_W-1:0]          rad_next;

    always_comb
    begin
        rem_shift = {rem_reg[cdgm_pkg::REM_W-3:0], rad_reg[cdgm_pkg::RAD_W-1 -: 2]};
        trial     = cdgm_pkg::REM_W'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
        rem_next  = fits ? (rem_shift - trial) : rem_shift;
        root_next = {root_reg[cdgm_pkg::MAG_W-2:0], fits};
        rad_next  = {rad_reg[cdgm_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cdgm_pkg::ITER_CNT_W'(cdgm_pkg::MAG_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != cdgm_pkg::ITER_CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.root = root_reg;

endmodule

// File: rtl/central_difference_gradient_magnitude.sv
// Flow: a pixel or drain transaction that yields a result passes through four history reads,
// difference, squares, sum and a 17-step square root before it shows on res.
// No new transaction is accepted until the sequencer is back in idle; a stalled res holds it
// in the root state. A transaction with no result (first row, ignored pixel or drain) stays in idle.
// Reset: rst_n (async, active low) clears counters, sequencer and result valid, and
// sets frame_width 640, frame_height 480; the row history is not cleared.
`include "assert_macros.svh"

module central_difference_gradient_magnitude (
    input  logic   clk,
    input  logic   rst_n,
    cdgm_pix_if.sink   pix,
    cdgm_res_if.source res,
    cdgm_cfg_if.sink   cfg
);

    cdgm_pkg::seq_state_t state_reg, state_next;

    logic [cdgm_pkg::WIDTH_W-1:0]  frame_width_reg, frame_width_next;
    logic [cdgm_pkg::HEIGHT_W-1:0] frame_height_reg, frame_height_next;
    logic [cdgm_pkg::COL_W-1:0]    in_col_reg, in_col_next;
    logic [cdgm_pkg::IN_ROW_W-1:0] in_row_reg, in_row_next;
    logic [cdgm_pkg::COL_W-1:0]    out_col_reg, out_col_next;
    logic [cdgm_pkg::ROW_W-1:0]    out_row_reg, out_row_next;
    logic                          out_valid_reg, out_valid_next;

    logic [cdgm_pkg::WIDTH_W-1:0]  w_eff;
    logic [cdgm_pkg::HEIGHT_W-1:0] h_eff;

    logic accept, cfg_we;
    logic pix_take, pix_emit, drn_emit, emit, last;
    logic [cdgm_pkg::WIDTH_W-1:0]  in_col_inc, out_col_inc;
    logic [cdgm_pkg::IN_ROW_W-1:0] out_row_inc;
    logic in_col_wrap, out_col_wrap, out_row_final;

    logic [cdgm_pkg::COL_W-1:0]  col_l, col_r;
    logic [cdgm_pkg::ADDR_W-1:0] addr_l, addr_r, addr_c, addr_a, addr_w;

    logic [cdgm_pkg::ADDR_W-1:0]         addr_l_reg, addr_r_reg, addr_c_reg, addr_a_reg;
    logic [cdgm_pkg::ADDR_W-1:0]         wr_addr_reg;
    logic signed [cdgm_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                drain_reg, last_reg;

    logic signed [cdgm_pkg::SAMPLE_W-1:0] left_reg, right_reg, centre_reg;
    logic signed [cdgm_pkg::SAMPLE_W-1:0] below;
    logic signed [cdgm_pkg::GRAD_W-1:0]   gx_reg, gy_reg, gx_next, gy_next;
    logic [cdgm_pkg::GRAD_W-1:0]          ax_full, ay_full;
    logic [cdgm_pkg::ABS_W-1:0]           ax, ay;
    logic [cdgm_pkg::SQ_W-1:0]            sq_x_reg, sq_y_reg;

    logic                                 mem_we, mem_re;
    logic [cdgm_pkg::ADDR_W-1:0]          mem_waddr, mem_raddr;
    logic [cdgm_pkg::SAMPLE_W-1:0]        mem_wdata, mem_rdata;

    cdgm_pkg::sqrt_req_t sqrt_req;
    cdgm_pkg::sqrt_rsp_t sqrt_rsp;

    logic out_free, load_out;

    logic signed [cdgm_pkg::GRAD_W-1:0] grad_x_reg, grad_y_reg;
    logic [cdgm_pkg::MAG_W-1:0]         magnitude_reg;
    logic                               frame_end_reg;

    cdgm_ram #(
        .ADDR_W (cdgm_pkg::ADDR_W),
        .DATA_W (cdgm_pkg::SAMPLE_W)
    ) u_history (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cdgm_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = cdgm_pkg::WIDTH_W'(1);
        end
        else if (frame_width_reg > cdgm_pkg::WIDTH_W'(cdgm_pkg::MAX_WIDTH))
        begin
            w_eff = cdgm_pkg::WIDTH_W'(cdgm_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = frame_width_reg;
        end

        if (frame_height_reg == '0)
        begin
            h_eff = cdgm_pkg::HEIGHT_W'(1);
        end
        else if (frame_height_reg > cdgm_pkg::HEIGHT_W'(cdgm_pkg::HEIGHT_LIMIT))
        begin
            h_eff = cdgm_pkg::HEIGHT_W'(cdgm_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
    end

    assign accept = pix.valid && pix.ready;
    assign cfg_we = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        in_col_inc    = cdgm_pkg::WIDTH_W'(in_col_reg) + cdgm_pkg::WIDTH_W'(1);
        out_col_inc   = cdgm_pkg::WIDTH_W'(out_col_reg) + cdgm_pkg::WIDTH_W'(1);
        out_row_inc   = cdgm_pkg::IN_ROW_W'(out_row_reg) + cdgm_pkg::IN_ROW_W'(1);
        in_col_wrap   = (in_col_inc >= w_eff);
        out_col_wrap  = (out_col_inc >= w_eff);
        out_row_final = (out_row_inc >= h_eff);

        pix_take = accept && !pix.cmd && (in_row_reg < h_eff);
        pix_emit = pix_take && (in_row_reg != '0);
        drn_emit = accept && pix.cmd && (in_row_reg >= h_eff)
                   && (cdgm_pkg::IN_ROW_W'(out_row_reg) < h_eff);
        emit     = pix_emit || drn_emit;
        last     = drn_emit && out_row_final && out_col_wrap;

        col_l  = (out_col_reg == '0) ? out_col_reg : out_col_reg - 1'b1;
        col_r  = out_col_wrap ? out_col_reg : out_col_inc[cdgm_pkg::COL_W-1:0];
        addr_l = {out_row_reg[0], col_l};
        addr_r = {out_row_reg[0], col_r};
        addr_c = {out_row_reg[0], out_col_reg};
        addr_a = (out_row_reg == '0) ? addr_c : {~out_row_reg[0], out_col_reg};
        addr_w = {in_row_reg[0], in_col_reg};
    end

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;

        if (cfg_we)
        begin
            case (cfg.index)
                cdgm_pkg::CFG_FRAME_WIDTH:
                begin
                    frame_width_next = cfg.data[cdgm_pkg::WIDTH_W-1:0];
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                cdgm_pkg::CFG_FRAME_HEIGHT:
                begin
                    frame_height_next = cfg.data[cdgm_pkg::HEIGHT_W-1:0];
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (pix_take)
            begin
                if (in_col_wrap)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_inc[cdgm_pkg::COL_W-1:0];
                end
            end
            if (emit)
            begin
                if (out_col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_inc[cdgm_pkg::COL_W-1:0];
                end
            end
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        pix.ready         = 1'b0;
        mem_re            = 1'b0;
        mem_raddr         = addr_l_reg;
        mem_we            = 1'b0;
        mem_waddr         = addr_w;
        mem_wdata         = pix.sample;
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = cdgm_pkg::RAD_W'(sq_x_reg) + cdgm_pkg::RAD_W'(sq_y_reg);
        load_out          = 1'b0;

        case (state_reg)
            cdgm_pkg::ST_IDLE:
            begin
                pix.ready = 1'b1;
                mem_we    = pix_take && !pix_emit;
            end
            cdgm_pkg::ST_RD_L:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_l_reg;
            end
            cdgm_pkg::ST_RD_R:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_r_reg;
            end
            cdgm_pkg::ST_RD_C:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_c_reg;
            end
            cdgm_pkg::ST_RD_A:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_a_reg;
            end
            cdgm_pkg::ST_DIFF:
            begin
                mem_we    = !drain_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = sample_reg;
            end
            cdgm_pkg::ST_SUM:
            begin
                sqrt_req.start = 1'b1;
            end
            cdgm_pkg::ST_ROOT:
            begin
                load_out = !sqrt_rsp.busy && out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdgm_pkg::ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = cdgm_pkg::ST_RD_L;
                end
            end
            cdgm_pkg::ST_RD_L:   state_next = cdgm_pkg::ST_RD_R;
            cdgm_pkg::ST_RD_R:   state_next = cdgm_pkg::ST_RD_C;
            cdgm_pkg::ST_RD_C:   state_next = cdgm_pkg::ST_RD_A;
            cdgm_pkg::ST_RD_A:   state_next = cdgm_pkg::ST_DIFF;
            cdgm_pkg::ST_DIFF:   state_next = cdgm_pkg::ST_SQUARE;
            cdgm_pkg::ST_SQUARE: state_next = cdgm_pkg::ST_SUM;
            cdgm_pkg::ST_SUM:    state_next = cdgm_pkg::ST_ROOT;
            cdgm_pkg::ST_ROOT:
            begin
                if (load_out)
                begin
                    state_next = cdgm_pkg::ST_IDLE;
                end
            end
            default:             state_next = cdgm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        below   = drain_reg ? centre_reg : sample_reg;
        gx_next = cdgm_pkg::GRAD_W'(right_reg) - cdgm_pkg::GRAD_W'(left_reg);
        gy_next = cdgm_pkg::GRAD_W'(below)
                  - cdgm_pkg::GRAD_W'(signed'(mem_rdata));
        ax_full = gx_reg[cdgm_pkg::GRAD_W-1] ? (cdgm_pkg::GRAD_W'(0) - gx_reg) : gx_reg;
        ay_full = gy_reg[cdgm_pkg::GRAD_W-1] ? (cdgm_pkg::GRAD_W'(0) - gy_reg) : gy_reg;
        ax      = ax_full[cdgm_pkg::ABS_W-1:0];
        ay      = ay_full[cdgm_pkg::ABS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cdgm_pkg::ST_IDLE;
            frame_width_reg  <= cdgm_pkg::WIDTH_W'(cdgm_pkg::WIDTH_RESET);
            frame_height_reg <= cdgm_pkg::HEIGHT_W'(cdgm_pkg::HEIGHT_RESET);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == cdgm_pkg::ST_IDLE) && emit)
        begin
            addr_l_reg  <= addr_l;
            addr_r_reg  <= addr_r;
            addr_c_reg  <= addr_c;
            addr_a_reg  <= addr_a;
            wr_addr_reg <= addr_w;
            sample_reg  <= pix.sample;
            drain_reg   <= drn_emit;
            last_reg    <= last;
        end
        if (state_reg == cdgm_pkg::ST_RD_R)
        begin
            left_reg <= mem_rdata;
        end
        if (state_reg == cdgm_pkg::ST_RD_C)
        begin
            right_reg <= mem_rdata;
        end
        if (state_reg == cdgm_pkg::ST_RD_A)
        begin
            centre_reg <= mem_rdata;
        end
        if (state_reg == cdgm_pkg::ST_DIFF)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (state_reg == cdgm_pkg::ST_SQUARE)
        begin
            sq_x_reg <= ax * ax;
            sq_y_reg <= ay * ay;
        end
        if (load_out)
        begin
            grad_x_reg    <= gx_reg;
            grad_y_reg    <= gy_reg;
            magnitude_reg <= sqrt_rsp.root;
            frame_end_reg <= last_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.grad_x    = grad_x_reg;
    assign res.grad_y    = grad_y_reg;
    assign res.magnitude = magnitude_reg;
    assign res.frame_end = frame_end_reg;

    `ASSERT_RST(a_idle_root_free, clk, rst_n, (state_reg == cdgm_pkg::ST_IDLE) |-> !sqrt_rsp.busy, "root unit busy while sequencer idle")
    `ASSERT_RST(a_root_started, clk, rst_n, (state_reg == cdgm_pkg::ST_SUM) |=> sqrt_rsp.busy, "root unit not started")
    `ASSERT_RST(a_write_slot, clk, rst_n, mem_we |-> ((state_reg == cdgm_pkg::ST_IDLE) || (state_reg == cdgm_pkg::ST_DIFF)), "history write outside its slot")
    `ASSERT_RST(a_col_range, clk, rst_n, (cdgm_pkg::WIDTH_W'(in_col_reg) < w_eff) && (cdgm_pkg::WIDTH_W'(out_col_reg) < w_eff), "column counter beyond row width")
    `ASSERT_ALWAYS(a_last_restart, clk, (rst_n && (state_reg != cdgm_pkg::ST_IDLE) && last_reg) |-> ((in_row_reg == '0) && (out_row_reg == '0)), "frame end without restart")

endmodule
